/* src/bblur_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helpers for the 3x3 box blur core.
// No dependencies.
package bblur_pkg;

   localparam int MAX_WIDTH_DEF = 1024;
   localparam logic [10:0] WIDTH_RESET = 11'd640;
   localparam logic [15:0] HEIGHT_RESET = 16'd480;

   // register indexes (paddr[2])
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   localparam int RECIP_SHIFT = 20;

   typedef logic [23:0] pixel_type;
   typedef pixel_type [8:0] window_type;

   typedef struct packed {
      logic       emit;
      logic       last;
      logic [8:0] mask;
      logic [3:0] count;
   } tap_ctl_type;

   // ceil(2^20 / (2*count)); zero for an empty neighborhood gives a zero average
   function automatic logic [19:0] recip(input logic [3:0] count);
      logic [19:0] m;
      case (count)
         4'd1:    m = 20'd524288;
         4'd2:    m = 20'd262144;
         4'd3:    m = 20'd174763;
         4'd4:    m = 20'd131072;
         4'd6:    m = 20'd87382;
         4'd9:    m = 20'd58255;
         default: m = 20'd0;
      endcase
      return m;
   endfunction

endpackage

/* src/bblur_req_if.sv */
`timescale 1ns / 1ps
// Pixel request channel: valid/ready handshake with pixel payload.
// No dependencies.
interface bblur_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] in_red;
   logic [7:0] in_green;
   logic [7:0] in_blue;

   modport source (output valid, action, in_red, in_green, in_blue, input ready);
   modport sink (input valid, action, in_red, in_green, in_blue, output ready);
endinterface

/* src/bblur_rsp_if.sv */
`timescale 1ns / 1ps
// Blurred pixel response channel: valid/ready handshake with result payload.
// No dependencies.
interface bblur_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_red;
   logic [7:0] out_green;
   logic [7:0] out_blue;
   logic       last_pixel;

   modport source (output valid, out_red, out_green, out_blue, last_pixel, input ready);
   modport sink (input valid, out_red, out_green, out_blue, last_pixel, output ready);
endinterface

/* src/box_blur_3x3_edge_average_core.sv */
`timescale 1ns / 1ps
// Top level of the 3x3 box blur with edge-aware averaging.
// Depends on bblur_pkg, bblur_req_if, bblur_rsp_if, bblur_avg.
//
// Usage:
//  - req_chan carries one transaction per pixel in raster order (action 0) or a
//    flush tick (action 1, no pixel). rsp_chan returns the blurred pixel for the
//    position one row and one pixel behind; last_pixel marks the frame's end.
//    Send image_width+1 flush ticks after a frame to drain it.
//  - Throughput: one transaction per clock unless rsp_chan stalls. The line
//    stores sit in a single 48-bit memory, read and written once per transaction.
//  - Pipeline: four register stages (memory read, window, sum, divide); a result
//    is valid on rsp_chan once it has passed through all four in order.
//  - When rsp_chan stalls with a result waiting, the whole pipeline holds and
//    req_chan.ready drops in the same cycle, even if earlier stages hold bubbles.
//  - Reset clears position counters, window and pipeline valids; width returns
//    to 640 and height to 480. Line stores are not cleared.
//  - Config (APB): width at 0x0, height at 0x4; write only while idle.
module box_blur_3x3_edge_average_core #(
   parameter int MAX_WIDTH = bblur_pkg::MAX_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   bblur_req_if.sink   req_chan,
   bblur_rsp_if.source rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import bblur_pkg::*;

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WW = CW + 1;

   // configuration
   logic [10:0] width_ff;
   logic [15:0] height_ff;
   logic [WW-1:0] eff_w;
   logic [15:0]   eff_h;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (psel && penable && pwrite) begin
         unique case (paddr[2])
            REG_WIDTH:  width_ff  <= pwdata[10:0];
            REG_HEIGHT: height_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_WIDTH) ? {21'b0, width_ff} : {16'b0, height_ff};

   always_comb begin
      if (width_ff == 11'd0) begin
         eff_w = WW'(1);
      end else if ({3'b0, width_ff} > 14'(MAX_WIDTH)) begin
         eff_w = WW'(MAX_WIDTH);
      end else begin
         eff_w = WW'(width_ff);
      end
   end
   assign eff_h = (height_ff == 16'd0) ? 16'd1 : height_ff;

   // pipeline control: everything advances together when the output can move
   logic en, accept, out_valid;
   assign en = !out_valid || rsp_chan.ready;
   assign req_chan.ready = en;
   assign accept = req_chan.valid && en;

   // position counters (input side runs one row and one pixel ahead)
   logic [CW-1:0] icol_ff, icol_in, ocol_ff, ocol_in;
   logic [16:0]   irow_ff, irow_in, orow_ff, orow_in;
   logic          emit, last, icol_wrap, ocol_wrap;
   logic [17:0]   orow_p1;
   logic [2:0]    row_ok, col_ok;
   tap_ctl_type   ctl0;

   assign orow_p1   = {1'b0, orow_ff} + 18'd1;
   assign icol_wrap = ({1'b0, icol_ff} + WW'(1)) >= eff_w;
   assign ocol_wrap = ({1'b0, ocol_ff} + WW'(1)) >= eff_w;
   assign emit = ({1'b0, irow_ff} > orow_p1) ||
                 (({1'b0, irow_ff} == orow_p1) && (icol_ff > ocol_ff));
   assign last = (orow_p1 >= {2'b0, eff_h}) && ocol_wrap;

   // which neighbor rows and columns lie inside the image
   assign row_ok[0] = (orow_ff != 17'd0) && ((orow_ff - 17'd1) < {1'b0, eff_h});
   assign row_ok[1] = orow_ff < {1'b0, eff_h};
   assign row_ok[2] = orow_p1 < {2'b0, eff_h};
   assign col_ok[0] = (ocol_ff != '0) && (({1'b0, ocol_ff} - WW'(1)) < eff_w);
   assign col_ok[1] = {1'b0, ocol_ff} < eff_w;
   assign col_ok[2] = ({1'b0, ocol_ff} + WW'(1)) < eff_w;

   always_comb begin
      ctl0.emit = emit;
      ctl0.last = last;
      for (int k = 0; k < 9; k++) begin
         ctl0.mask[k] = row_ok[k / 3] && col_ok[k % 3];
      end
      ctl0.count = 4'($countones(ctl0.mask));
   end

   always_comb begin
      icol_in = icol_ff;
      irow_in = irow_ff;
      ocol_in = ocol_ff;
      orow_in = orow_ff;
      if (accept) begin
         if (icol_wrap) begin
            icol_in = '0;
            irow_in = irow_ff + 17'd1;
         end else begin
            icol_in = icol_ff + CW'(1);
         end
         if (emit) begin
            if (ocol_wrap) begin
               ocol_in = '0;
               orow_in = orow_ff + 17'd1;
            end else begin
               ocol_in = ocol_ff + CW'(1);
            end
            if (last) begin
               icol_in = '0;
               irow_in = '0;
               ocol_in = '0;
               orow_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         icol_ff <= '0;
         irow_ff <= '0;
         ocol_ff <= '0;
         orow_ff <= '0;
      end else begin
         icol_ff <= icol_in;
         irow_ff <= irow_in;
         ocol_ff <= ocol_in;
         orow_ff <= orow_in;
      end
   end

   // stage 1: line store read returns; window shifts and store is written back
   logic [47:0]   store_mem [MAX_WIDTH];
   logic [47:0]   rd_ff;
   logic          s1_valid_ff;
   tap_ctl_type   s1_ctl_ff;
   pixel_type     s1_pix_ff, s1_fwd_up_ff, s1_fwd_mid_ff, s1_up, s1_mid, pix0;
   logic [CW-1:0] s1_addr_ff;
   logic          s1_fwd_ff;

   assign pix0 = req_chan.action ? 24'd0
                 : {req_chan.in_red, req_chan.in_green, req_chan.in_blue};

   // back-to-back hit on the same column: take the values being written now
   assign s1_up  = s1_fwd_ff ? s1_fwd_up_ff  : rd_ff[47:24];
   assign s1_mid = s1_fwd_ff ? s1_fwd_mid_ff : rd_ff[23:0];

   always_ff @(posedge clock) begin
      if (en) begin
         rd_ff <= store_mem[icol_ff];
      end
      if (en && s1_valid_ff) begin
         store_mem[s1_addr_ff] <= {s1_mid, s1_pix_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= accept;
      end
      if (en) begin
         s1_ctl_ff     <= ctl0;
         s1_pix_ff     <= pix0;
         s1_addr_ff    <= icol_ff;
         s1_fwd_ff     <= s1_valid_ff && (s1_addr_ff == icol_ff);
         s1_fwd_up_ff  <= s1_mid;
         s1_fwd_mid_ff <= s1_pix_ff;
      end
   end

   // 3x3 window: rows top, middle, bottom; column 2 is the newest
   window_type  win_ff;
   tap_ctl_type win_ctl_ff, win_ctl_in;

   always_comb begin
      win_ctl_in      = s1_ctl_ff;
      win_ctl_in.emit = s1_valid_ff && s1_ctl_ff.emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff     <= '0;
         win_ctl_ff <= '0;
      end else if (en) begin
         if (s1_valid_ff) begin
            for (int r = 0; r < 3; r++) begin
               win_ff[3*r]     <= win_ff[3*r+1];
               win_ff[3*r+1]   <= win_ff[3*r+2];
            end
            win_ff[2] <= s1_up;
            win_ff[5] <= s1_mid;
            win_ff[8] <= s1_pix_ff;
         end
         win_ctl_ff <= win_ctl_in;
      end
   end

   bblur_avg u_avg (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .win       (win_ff),
      .ctl       (win_ctl_ff),
      .out_valid (out_valid),
      .out_red   (rsp_chan.out_red),
      .out_green (rsp_chan.out_green),
      .out_blue  (rsp_chan.out_blue),
      .out_last  (rsp_chan.last_pixel)
   );

   assign rsp_chan.valid = out_valid;
endmodule

/* src/bblur_avg.sv */
`timescale 1ns / 1ps
// Masked 3x3 sums and rounded division by the neighbor count, plus output register.
// Depends on bblur_pkg.
module bblur_avg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  bblur_pkg::window_type win,
   input  bblur_pkg::tap_ctl_type ctl,
   output logic                  out_valid,
   output logic [7:0]            out_red,
   output logic [7:0]            out_green,
   output logic [7:0]            out_blue,
   output logic                  out_last
);
   import bblur_pkg::*;

   logic [11:0] sum_r, sum_g, sum_b;
   logic        a_emit_ff, a_last_ff;
   logic [12:0] a_nr_ff, a_ng_ff, a_nb_ff;
   logic [19:0] a_m_ff;
   logic [32:0] pr_r, pr_g, pr_b;
   logic        out_valid_ff, out_last_ff;
   logic [7:0]  out_r_ff, out_g_ff, out_b_ff;

   always_comb begin
      sum_r = '0;
      sum_g = '0;
      sum_b = '0;
      for (int k = 0; k < 9; k++) begin
         if (ctl.mask[k]) begin
            sum_r = sum_r + {4'b0, win[k][23:16]};
            sum_g = sum_g + {4'b0, win[k][15:8]};
            sum_b = sum_b + {4'b0, win[k][7:0]};
         end
      end
   end

   // stage A: numerator 2*sum+count and reciprocal of 2*count
   always_ff @(posedge clock) begin
      if (reset) begin
         a_emit_ff <= 1'b0;
      end else if (en) begin
         a_emit_ff <= ctl.emit;
      end
      if (en) begin
         a_last_ff <= ctl.last;
         a_nr_ff   <= {sum_r, 1'b0} + {9'b0, ctl.count};
         a_ng_ff   <= {sum_g, 1'b0} + {9'b0, ctl.count};
         a_nb_ff   <= {sum_b, 1'b0} + {9'b0, ctl.count};
         a_m_ff    <= recip(ctl.count);
      end
   end

   assign pr_r = {20'b0, a_nr_ff} * {13'b0, a_m_ff};
   assign pr_g = {20'b0, a_ng_ff} * {13'b0, a_m_ff};
   assign pr_b = {20'b0, a_nb_ff} * {13'b0, a_m_ff};

   // stage B: output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= a_emit_ff;
      end
      if (en) begin
         out_last_ff <= a_last_ff;
         out_r_ff    <= pr_r[RECIP_SHIFT+7:RECIP_SHIFT];
         out_g_ff    <= pr_g[RECIP_SHIFT+7:RECIP_SHIFT];
         out_b_ff    <= pr_b[RECIP_SHIFT+7:RECIP_SHIFT];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_red   = out_r_ff;
   assign out_green = out_g_ff;
   assign out_blue  = out_b_ff;
   assign out_last  = out_last_ff;
endmodule
